/* src/wtt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the waypoint trajectory tracker.
// Used by the controller, the datapath, the top level and the checker.
package wtt_pkg;

  localparam int MAX_WAYPOINTS = 64;
  localparam int AW            = $clog2(MAX_WAYPOINTS);
  localparam int IW            = $clog2(MAX_WAYPOINTS + 1);

  localparam logic [31:0] SPEED_RESET  = 32'd13107;
  localparam logic [31:0] THRESH_RESET = 32'd1638;

  // configuration register indexes
  localparam logic CFG_SPEED  = 1'b0;
  localparam logic CFG_THRESH = 1'b1;

  // item kinds
  localparam logic [2:0] KIND_CLEAR    = 3'd0;
  localparam logic [2:0] KIND_LOAD     = 3'd1;
  localparam logic [2:0] KIND_RESET    = 3'd2;
  localparam logic [2:0] KIND_PLAY     = 3'd3;
  localparam logic [2:0] KIND_PAUSE    = 3'd4;
  localparam logic [2:0] KIND_TICK     = 3'd5;
  localparam logic [2:0] KIND_FEEDBACK = 3'd6;

  // axis select
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic {
    SRC_GOAL,
    SRC_POS
  } src_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLEAR,
    OP_LOAD,
    OP_RESET,
    OP_PLAY,
    OP_PAUSE,
    OP_TICK_NONE,
    OP_GAPS_ZERO,
    OP_RD,
    OP_SQ,
    OP_ACC,
    OP_RT_INIT,
    OP_RT_STEP,
    OP_SET_BOTH,
    OP_SET_GGAP,
    OP_SET_TGAP,
    OP_GG_CPCLR,
    OP_GG_CPSET,
    OP_SET_D,
    OP_STEP_MUL,
    OP_STEP,
    OP_SNAP,
    OP_AXMUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_AXUPD,
    OP_CP_CLR,
    OP_ADV,
    OP_FINISH,
    OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RST2,
    ST_RD,
    ST_SQ,
    ST_ACC,
    ST_RT_INIT,
    ST_RT,
    ST_DD,
    ST_STEP_MUL,
    ST_STEP,
    ST_MOVE,
    ST_AXMUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_AXUPD,
    ST_FB_CHK,
    ST_ADV,
    ST_ADV2,
    ST_OUT
  } state_t;

  // what to do with a finished distance
  typedef enum logic [2:0] {
    PH_RESET,
    PH_TICK_IDLE,
    PH_TICK_D,
    PH_TICK_G,
    PH_FB_G,
    PH_FB_T,
    PH_FB2_G,
    PH_FB2_T
  } phase_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    src_t       src;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       has_point;
    logic       playing;
    logic       done;
    logic       check_pending;
    logic       reach_ok;
    logic       dist_zero;
    logic       snap;
    logic       step_zero;
  } status_t;

  // magnitude of a 33-bit difference of two 32-bit signed values
  function automatic logic [31:0] mag33(input logic [32:0] d);
    logic [32:0] n;
    n = ~d + 33'd1;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

endpackage

/* src/wtt_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the tracker: decodes each item into datapath commands.
// Depends on wtt_pkg.
module wtt_ctrl
  import wtt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t     state, state_next;
  phase_t     phase, phase_next;
  src_t       src, src_next;
  logic [1:0] axis, axis_next;
  logic [4:0] cnt, cnt_next;
  logic       out_valid_next;

  // state and sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_RESET;
      src       <= SRC_GOAL;
      axis      <= AX_X;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      src       <= src_next;
      axis      <= axis_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    src_next       = src;
    axis_next      = axis;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = OP_NONE;
    cmd.axis       = axis;
    cmd.src        = src;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        state_next = ST_OUT;
        src_next   = SRC_GOAL;
        unique case (sts.kind)
          KIND_CLEAR: cmd.op = OP_CLEAR;
          KIND_LOAD:  cmd.op = OP_LOAD;
          KIND_RESET: begin
            cmd.op     = OP_RESET;
            state_next = ST_RST2;
          end
          KIND_PLAY:  cmd.op = OP_PLAY;
          KIND_PAUSE: cmd.op = OP_PAUSE;
          KIND_TICK: begin
            if (!sts.has_point) begin
              cmd.op = OP_TICK_NONE;
            end else begin
              phase_next = (sts.playing && !sts.done) ? PH_TICK_D : PH_TICK_IDLE;
              state_next = ST_RD;
            end
          end
          KIND_FEEDBACK: begin
            if (!sts.has_point) begin
              cmd.op = OP_GAPS_ZERO;
            end else begin
              phase_next = PH_FB_G;
              state_next = ST_RD;
            end
          end
          default: cmd.op = OP_NONE;
        endcase
      end

      ST_RST2: begin
        if (sts.has_point) begin
          phase_next = PH_RESET;
          state_next = ST_RD;
        end else begin
          state_next = ST_OUT;
        end
      end

      // fetch the current waypoint
      ST_RD: begin
        cmd.op     = OP_RD;
        axis_next  = AX_X;
        state_next = ST_SQ;
      end

      // sum of squares, one axis at a time
      ST_SQ: begin
        cmd.op     = OP_SQ;
        state_next = ST_ACC;
      end

      ST_ACC: begin
        cmd.op = OP_ACC;
        if (axis == AX_Z) begin
          state_next = ST_RT_INIT;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_SQ;
        end
      end

      ST_RT_INIT: begin
        cmd.op     = OP_RT_INIT;
        cnt_next   = '0;
        state_next = ST_RT;
      end

      // one root bit per cycle
      ST_RT: begin
        cmd.op   = OP_RT_STEP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) state_next = ST_DD;
      end

      // route the finished distance
      ST_DD: begin
        unique case (phase)
          PH_RESET: begin
            cmd.op     = OP_SET_BOTH;
            state_next = ST_OUT;
          end
          PH_TICK_IDLE: begin
            cmd.op     = OP_GG_CPCLR;
            state_next = ST_OUT;
          end
          PH_TICK_D: begin
            cmd.op     = OP_SET_D;
            state_next = ST_STEP_MUL;
          end
          PH_TICK_G: begin
            cmd.op     = OP_GG_CPSET;
            state_next = ST_OUT;
          end
          PH_FB_G: begin
            cmd.op     = OP_SET_GGAP;
            phase_next = PH_FB_T;
            src_next   = SRC_POS;
            axis_next  = AX_X;
            state_next = ST_SQ;
          end
          PH_FB_T: begin
            cmd.op     = OP_SET_TGAP;
            state_next = ST_FB_CHK;
          end
          PH_FB2_G: begin
            cmd.op     = OP_SET_GGAP;
            phase_next = PH_FB2_T;
            src_next   = SRC_POS;
            axis_next  = AX_X;
            state_next = ST_SQ;
          end
          PH_FB2_T: begin
            cmd.op     = OP_SET_TGAP;
            state_next = ST_OUT;
          end
          default: state_next = ST_OUT;
        endcase
      end

      ST_STEP_MUL: begin
        cmd.op     = OP_STEP_MUL;
        state_next = ST_STEP;
      end

      ST_STEP: begin
        cmd.op     = OP_STEP;
        state_next = ST_MOVE;
      end

      // snap, hold, or move along the direction
      ST_MOVE: begin
        src_next  = SRC_GOAL;
        axis_next = AX_X;
        if (sts.dist_zero || sts.step_zero || sts.snap) begin
          if (!sts.dist_zero && sts.snap) cmd.op = OP_SNAP;
          phase_next = PH_TICK_G;
          state_next = ST_SQ;
        end else begin
          state_next = ST_AXMUL;
        end
      end

      ST_AXMUL: begin
        cmd.op     = OP_AXMUL;
        state_next = ST_DIV_INIT;
      end

      ST_DIV_INIT: begin
        cmd.op     = OP_DIV_INIT;
        cnt_next   = '0;
        state_next = ST_DIV;
      end

      // one quotient bit per cycle
      ST_DIV: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) state_next = ST_AXUPD;
      end

      ST_AXUPD: begin
        cmd.op = OP_AXUPD;
        if (axis == AX_Z) begin
          phase_next = PH_TICK_G;
          axis_next  = AX_X;
          state_next = ST_SQ;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_AXMUL;
        end
      end

      // reach test on a pending check
      ST_FB_CHK: begin
        state_next = ST_OUT;
        if (sts.check_pending) begin
          cmd.op = OP_CP_CLR;
          if (sts.reach_ok) state_next = ST_ADV;
        end
      end

      ST_ADV: begin
        cmd.op     = OP_ADV;
        state_next = ST_ADV2;
      end

      ST_ADV2: begin
        if (!sts.has_point) begin
          cmd.op     = OP_FINISH;
          state_next = ST_OUT;
        end else begin
          phase_next = PH_FB2_G;
          src_next   = SRC_GOAL;
          state_next = ST_RD;
        end
      end

      // hand the result to the output register once it is free
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.op         = OP_OUT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* src/wtt_dp.sv */
`timescale 1ns / 1ps
// Tracker datapath: waypoint table, tracking state, shared multiplier,
// bit-serial square root and divider, output register. Depends on wtt_pkg.
module wtt_dp
  import wtt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  output status_t       sts,
  input  logic [2:0]    kind,
  input  logic [31:0]   dt,
  input  logic [31:0]   pos_x,
  input  logic [31:0]   pos_y,
  input  logic [31:0]   pos_z,
  input  logic [AW-1:0] slot,
  input  logic          final_load,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data,
  output logic [31:0]   target_x,
  output logic [31:0]   target_y,
  output logic [31:0]   target_z,
  output logic [IW-1:0] waypoint_index,
  output logic          is_playing,
  output logic          is_finished,
  output logic [31:0]   target_distance,
  output logic [31:0]   tool_distance
);

  // waypoint table
  logic [95:0] mem [MAX_WAYPOINTS];
  logic [31:0] wp_x, wp_y, wp_z;

  // latched item
  logic [2:0]    it_kind;
  logic [31:0]   it_dt, it_x, it_y, it_z;
  logic [AW-1:0] it_slot;
  logic          it_fin;

  // tracking state
  logic [31:0]   speed, thresh;
  logic [IW-1:0] pcount, cur;
  logic          playing, done, cpend;
  logic [31:0]   goal_x, goal_y, goal_z, goal_gap, tip_gap;

  // arithmetic working registers
  logic [63:0] prod, acc, rad;
  logic        sat;
  logic [33:0] rem;
  logic [31:0] root, dval, step, dq, drem;
  logic        snap, step_zero;

  logic [31:0] src_x, src_y, src_z, sel_mag, mul_a, mul_b, gap_now;
  logic [32:0] dx, dy, dz, sel_diff;
  logic [64:0] acc_sum;
  logic [35:0] rt_sh, rt_diff;
  logic [32:0] dv_sh;
  logic        has_point;

  assign src_x = (cmd.src == SRC_POS) ? it_x : goal_x;
  assign src_y = (cmd.src == SRC_POS) ? it_y : goal_y;
  assign src_z = (cmd.src == SRC_POS) ? it_z : goal_z;
  assign dx    = {wp_x[31], wp_x} - {src_x[31], src_x};
  assign dy    = {wp_y[31], wp_y} - {src_y[31], src_y};
  assign dz    = {wp_z[31], wp_z} - {src_z[31], src_z};

  always_comb begin
    unique case (cmd.axis)
      AX_X:    sel_diff = dx;
      AX_Y:    sel_diff = dy;
      default: sel_diff = dz;
    endcase
  end
  assign sel_mag = mag33(sel_diff);

  // shared multiplier operand select
  always_comb begin
    unique case (cmd.op)
      OP_STEP_MUL: begin
        mul_a = speed;
        mul_b = it_dt;
      end
      OP_AXMUL: begin
        mul_a = sel_mag;
        mul_b = step;
      end
      default: begin
        mul_a = sel_mag;
        mul_b = sel_mag;
      end
    endcase
  end

  assign acc_sum  = {1'b0, acc} + {1'b0, prod};
  assign rt_sh    = {rem, rad[63:62]};
  assign rt_diff  = rt_sh - {2'b00, root, 2'b01};
  assign dv_sh    = {drem, dq[31]};
  assign gap_now  = sat ? '1 : root;
  assign has_point = cur < pcount;

  assign sts.kind          = it_kind;
  assign sts.has_point     = has_point;
  assign sts.playing       = playing;
  assign sts.done          = done;
  assign sts.check_pending = cpend;
  assign sts.reach_ok      = (goal_gap <= thresh) && (tip_gap <= thresh);
  assign sts.dist_zero     = (dval == '0);
  assign sts.snap          = snap;
  assign sts.step_zero     = step_zero;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) mem[it_slot] <= {it_x, it_y, it_z};
    if (cmd.op == OP_RD) {wp_x, wp_y, wp_z} <= mem[cur[AW-1:0]];
  end

  // latch the item
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      it_kind <= kind;
      it_dt   <= dt;
      it_x    <= pos_x;
      it_y    <= pos_y;
      it_z    <= pos_z;
      it_slot <= slot;
      it_fin  <= final_load;
    end
  end

  // multiply, square root and divide
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_SQ: begin
        prod <= mul_a * mul_b;
        if (cmd.axis == AX_X) begin
          acc <= '0;
          sat <= 1'b0;
        end
      end
      OP_STEP_MUL, OP_AXMUL: prod <= mul_a * mul_b;
      OP_ACC: begin
        acc <= acc_sum[63:0];
        sat <= sat | acc_sum[64];
      end
      OP_RT_INIT: begin
        rad  <= acc;
        rem  <= '0;
        root <= '0;
      end
      OP_RT_STEP: begin
        rad <= {rad[61:0], 2'b00};
        if (!rt_diff[35]) begin
          rem  <= rt_diff[33:0];
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rt_sh[33:0];
          root <= {root[30:0], 1'b0};
        end
      end
      OP_SET_D: dval <= gap_now;
      OP_STEP: begin
        step      <= prod[47:16];
        snap      <= (prod[63:48] != '0) || (prod[47:16] >= dval);
        step_zero <= (prod[63:16] == '0);
      end
      OP_DIV_INIT: begin
        drem <= prod[63:32];
        dq   <= prod[31:0];
      end
      OP_DIV_STEP: begin
        if (dv_sh >= {1'b0, dval}) begin
          drem <= dv_sh[31:0] - dval;
          dq   <= {dq[30:0], 1'b1};
        end else begin
          drem <= dv_sh[31:0];
          dq   <= {dq[30:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // tracking state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      speed    <= SPEED_RESET;
      thresh   <= THRESH_RESET;
      pcount   <= '0;
      cur      <= '0;
      playing  <= 1'b0;
      done     <= 1'b0;
      cpend    <= 1'b0;
      goal_x   <= '0;
      goal_y   <= '0;
      goal_z   <= '0;
      goal_gap <= '0;
      tip_gap  <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SPEED) speed <= cfg_data;
        else thresh <= cfg_data;
      end
      unique case (cmd.op)
        OP_CLEAR: begin
          pcount   <= '0;
          cur      <= '0;
          playing  <= 1'b0;
          done     <= 1'b1;
          goal_gap <= '0;
          tip_gap  <= '0;
          cpend    <= 1'b0;
        end
        OP_LOAD: begin
          if (it_fin) begin
            pcount   <= {1'b0, it_slot} + IW'(1);
            cur      <= '0;
            playing  <= 1'b0;
            done     <= 1'b0;
            goal_gap <= '0;
            tip_gap  <= '0;
            cpend    <= 1'b0;
          end
        end
        OP_RESET: begin
          cur      <= '0;
          playing  <= 1'b0;
          cpend    <= 1'b0;
          done     <= (pcount == '0);
          goal_x   <= it_x;
          goal_y   <= it_y;
          goal_z   <= it_z;
          goal_gap <= '0;
          tip_gap  <= '0;
        end
        OP_PLAY: begin
          if (has_point && !done) begin
            if (!playing) begin
              goal_x <= it_x;
              goal_y <= it_y;
              goal_z <= it_z;
            end
            playing <= 1'b1;
          end
        end
        OP_PAUSE: playing <= 1'b0;
        OP_TICK_NONE, OP_FINISH: begin
          playing  <= 1'b0;
          done     <= 1'b1;
          goal_gap <= '0;
          tip_gap  <= '0;
          if (cmd.op == OP_TICK_NONE) cpend <= 1'b0;
        end
        OP_GAPS_ZERO: begin
          goal_gap <= '0;
          tip_gap  <= '0;
          cpend    <= 1'b0;
        end
        OP_SET_BOTH: begin
          goal_gap <= gap_now;
          tip_gap  <= gap_now;
        end
        OP_SET_GGAP: goal_gap <= gap_now;
        OP_SET_TGAP: tip_gap  <= gap_now;
        OP_GG_CPCLR: begin
          goal_gap <= gap_now;
          cpend    <= 1'b0;
        end
        OP_GG_CPSET: begin
          goal_gap <= gap_now;
          cpend    <= 1'b1;
        end
        OP_SNAP: begin
          goal_x <= wp_x;
          goal_y <= wp_y;
          goal_z <= wp_z;
        end
        OP_AXUPD: begin
          unique case (cmd.axis)
            AX_X:    goal_x <= dx[32] ? goal_x - dq : goal_x + dq;
            AX_Y:    goal_y <= dy[32] ? goal_y - dq : goal_y + dq;
            default: goal_z <= dz[32] ? goal_z - dq : goal_z + dq;
          endcase
        end
        OP_CP_CLR: cpend <= 1'b0;
        OP_ADV:    cur   <= cur + IW'(1);
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      target_x        <= goal_x;
      target_y        <= goal_y;
      target_z        <= goal_z;
      waypoint_index  <= cur;
      is_playing      <= playing;
      is_finished     <= done;
      target_distance <= goal_gap;
      tool_distance   <= tip_gap;
    end
  end

endmodule

/* src/waypoint_trajectory_tracker.sv */
`timescale 1ns / 1ps
// Top level of the waypoint trajectory tracker: controller plus datapath.
// Depends on wtt_pkg, wtt_ctrl and wtt_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | kind dt pos_x pos_y pos_z slot final_load
//  out     | out_valid / out_ready| target_x/y/z waypoint_index is_playing
//          |                      | is_finished target_distance tool_distance
//  cfg     | cfg_we (no wait)     | cfg_index cfg_data
//
// Clear, load, play, pause and unknown kinds go from dispatch to the output state.
// Each distance takes the squares on the shared multiplier, the bit-serial root
// and a routing step, after a table read of the current waypoint; a reset takes
// one distance when the table has a point, an idle tick one, a moving tick two
// distances plus three divides unless it snaps or holds, and a feedback up to four.
// One item is in work at a time; the next is taken while a result waits.
// Reset is synchronous and clears all control state; the table needs no clearing.
module waypoint_trajectory_tracker
  import wtt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    kind,
  input  logic [31:0]   dt,
  input  logic [31:0]   pos_x,
  input  logic [31:0]   pos_y,
  input  logic [31:0]   pos_z,
  input  logic [AW-1:0] slot,
  input  logic          final_load,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   target_x,
  output logic [31:0]   target_y,
  output logic [31:0]   target_z,
  output logic [IW-1:0] waypoint_index,
  output logic          is_playing,
  output logic          is_finished,
  output logic [31:0]   target_distance,
  output logic [31:0]   tool_distance,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data
);

  cmd_t    cmd;
  status_t sts;

  wtt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wtt_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .kind            (kind),
    .dt              (dt),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .slot            (slot),
    .final_load      (final_load),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .target_x        (target_x),
    .target_y        (target_y),
    .target_z        (target_z),
    .waypoint_index  (waypoint_index),
    .is_playing      (is_playing),
    .is_finished     (is_finished),
    .target_distance (target_distance),
    .tool_distance   (tool_distance)
  );

endmodule

/* src/wtt_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the tracker, bound to the top level.
// Depends on wtt_pkg and waypoint_trajectory_tracker.
module wtt_checker
  import wtt_pkg::*;
(
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [31:0]   target_x,
  input logic [IW-1:0] waypoint_index,
  input logic          is_playing,
  input logic          is_finished
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(target_x) && $stable(waypoint_index))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  // a finished run never plays
  a_fin_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_finished && is_playing))
    else $error("finished and playing together");

  // index never passes the table size
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> waypoint_index <= IW'(MAX_WAYPOINTS))
    else $error("waypoint index out of range");

endmodule

bind waypoint_trajectory_tracker wtt_checker u_wtt_checker (.*);
